@@ hdl/lz77_pkg.sv @@
// lz77_pkg: shared types and constants for the lz77 token encoder
// no dependencies
package lz77_pkg;

   localparam logic FUNC_PUSH  = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   localparam int MIN_MATCH = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEARCH,
      ST_EMIT,
      ST_SHIFT
   } state_type;

   // token fields handed from the search engine to the output stage
   typedef struct packed {
      logic       is_match;
      logic [9:0] match_offset;
      logic [6:0] match_length;
      logic [7:0] next_byte;
      logic       tail_done;
   } token_type;

endpackage

@@ hdl/lz77_if.sv @@
// lz77_req_if / lz77_rsp_if: valid/ready channels of the encoder
// depends on lz77_pkg
interface lz77_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;
   modport source (output valid, func, data_byte, input ready);
   modport sink   (input valid, func, data_byte, output ready);
endinterface

interface lz77_rsp_if;
   import lz77_pkg::*;
   logic       valid;
   logic       ready;
   logic       is_match;
   logic [9:0] match_offset;
   logic [6:0] match_length;
   logic [7:0] next_byte;
   logic       tail_done;
   modport source (output valid, is_match, match_offset, match_length, next_byte,
                   tail_done, input ready);
   modport sink   (input valid, is_match, match_offset, match_length, next_byte,
                   tail_done, output ready);
endinterface

@@ hdl/lz77_token_encoder_core.sv @@
// lz77_token_encoder_core: top level of the lz77 token encoder
// depends on lz77_pkg, lz77_if, lz77_cell
//
//  channel  dir  transfer contents
//  req_     in   func, data_byte
//  rsp_     out  is_match, match_offset, match_length, next_byte, tail_done
//
// a push that does not fill the lookahead starts no search
// a token loads and steps the cell row, scans for the best match, emits, and
// then shifts the window by length+1 bytes (one for a literal), one byte at a
// time through the single shift path of the window row
// reset clears the window row, the lookahead count and the handshakes
// the token sits in an output register; pushes go on while it waits, and
// the next token holds in its emit cycle until the register is free
module lz77_token_encoder_core
   import lz77_pkg::*;
#(
   parameter int WINDOW_SIZE    = 1024,
   parameter int LOOKAHEAD_SIZE = 100
) (
   input  logic       clock,
   input  logic       reset,
   lz77_req_if.sink   req,
   lz77_rsp_if.source rsp
);
   localparam int BUF_DEPTH = LOOKAHEAD_SIZE + 1;
   localparam int LEN_W     = $clog2(BUF_DEPTH + 1);
   localparam int WIN_W     = $clog2(WINDOW_SIZE);
   localparam int BUF_W     = $clog2(BUF_DEPTH);

   // window row: a shift line, oldest byte at index 0
   logic [7:0] win_ff [WINDOW_SIZE];
   // lookahead buffer, shifted along with the window
   logic [7:0] la_ff [BUF_DEPTH];
   logic [LEN_W-1:0] count_ff;

   // search-time copy of the window that shifts down once per step, so cell i
   // sees window byte i+k at step k
   logic [7:0] rot_ff [WINDOW_SIZE];
   // search-time copy of the lookahead, byte k sits at index 0 at step k
   logic [7:0] la_rot_ff [BUF_DEPTH];
   logic [LEN_W-1:0] step_ff, limit_ff;
   logic [WIN_W:0]   scan_ff;
   logic [LEN_W-1:0] best_len_ff, shift_ff;
   logic [WIN_W-1:0] best_off_ff;
   logic             drain_ff;
   state_type        state_ff, state_in;

   logic             cell_start, cell_step;
   logic [LEN_W-1:0] run_len [WINDOW_SIZE];
   logic [7:0]       la_cur;

   assign la_cur     = la_rot_ff[0];
   assign cell_start = (state_ff == ST_LOAD);
   assign cell_step  = (state_ff == ST_SEARCH) && (step_ff < limit_ff);

   for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
      lz77_cell #(.LEN_W(LEN_W)) u_cell (
         .clock   (clock),
         .start   (cell_start),
         .step    (cell_step),
         .win_byte(rot_ff[g]),
         .la_byte (la_cur),
         .in_range((32'(g) + 32'(step_ff)) < WINDOW_SIZE),
         .run_len (run_len[g])
      );
   end

   // scan pass: the run lengths shift one cell per cycle towards index 0
   logic [LEN_W-1:0] res_ff [WINDOW_SIZE];

   logic o_valid_ff;
   logic req_fire, rsp_fire, emit_go;
   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;
   // the output register is free, or its token leaves in this cycle
   assign emit_go   = (state_ff == ST_EMIT) && (!o_valid_ff || rsp.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.func == FUNC_PUSH) begin
                  if (32'(count_ff) == BUF_DEPTH - 1) state_in = ST_LOAD;
               end else if (count_ff != '0) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD:   state_in = ST_SEARCH;
         ST_SEARCH: if (32'(scan_ff) == WINDOW_SIZE) state_in = ST_EMIT;
         ST_EMIT:   if (emit_go) state_in = ST_SHIFT;
         ST_SHIFT:  if (shift_ff == LEN_W'(1)) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // datapath
   logic shift_now;
   assign shift_now = (state_ff == ST_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < WINDOW_SIZE; i++) win_ff[i] <= '0;
      end else begin
         if (req_fire && req.func == FUNC_PUSH && 32'(count_ff) < BUF_DEPTH) begin
            la_ff[count_ff[BUF_W-1:0]] <= req.data_byte;
            count_ff <= count_ff + LEN_W'(1);
         end
         if (shift_now) begin
            for (int i = 0; i < WINDOW_SIZE - 1; i++) win_ff[i] <= win_ff[i+1];
            win_ff[WINDOW_SIZE-1] <= la_ff[0];
            for (int i = 0; i < BUF_DEPTH - 1; i++) la_ff[i] <= la_ff[i+1];
            la_ff[BUF_DEPTH-1] <= '0;
            count_ff <= count_ff - LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            drain_ff <= req.func;
            if (req.func == FUNC_PUSH) limit_ff <= LEN_W'(LOOKAHEAD_SIZE);
            else                       limit_ff <= count_ff - LEN_W'(1);
         end
         ST_LOAD: begin
            for (int i = 0; i < WINDOW_SIZE; i++) rot_ff[i] <= win_ff[i];
            for (int i = 0; i < BUF_DEPTH; i++) la_rot_ff[i] <= la_ff[i];
            step_ff     <= '0;
            scan_ff     <= '0;
            best_len_ff <= '0;
            best_off_ff <= '0;
         end
         ST_SEARCH: begin
            if (step_ff < limit_ff) begin
               for (int i = 0; i < WINDOW_SIZE - 1; i++) rot_ff[i] <= rot_ff[i+1];
               rot_ff[WINDOW_SIZE-1] <= '0;
               for (int i = 0; i < BUF_DEPTH - 1; i++) la_rot_ff[i] <= la_rot_ff[i+1];
               la_rot_ff[BUF_DEPTH-1] <= '0;
               step_ff <= step_ff + LEN_W'(1);
            end else if (step_ff == limit_ff) begin
               // the cell registers hold the runs after the last step, so capture them
               for (int i = 0; i < WINDOW_SIZE; i++) res_ff[i] <= run_len[i];
               step_ff <= step_ff + LEN_W'(1);
            end else begin
               if (res_ff[0] > best_len_ff) begin
                  best_len_ff <= res_ff[0];
                  best_off_ff <= scan_ff[WIN_W-1:0];
               end
               for (int i = 0; i < WINDOW_SIZE - 1; i++) res_ff[i] <= res_ff[i+1];
               res_ff[WINDOW_SIZE-1] <= '0;
               scan_ff <= scan_ff + (WIN_W+1)'(1);
            end
         end
         ST_EMIT: begin
            if (32'(best_len_ff) <= MIN_MATCH) shift_ff <= LEN_W'(1);
            else                               shift_ff <= best_len_ff + LEN_W'(1);
         end
         ST_SHIFT: shift_ff <= shift_ff - LEN_W'(1);
         default: ;
      endcase
   end

   // output register
   token_type  tok_ff;
   logic       big;
   assign big = 32'(best_len_ff) > MIN_MATCH;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         if (emit_go)       o_valid_ff <= 1'b1;
         else if (rsp_fire) o_valid_ff <= 1'b0;
      end
      if (emit_go) begin
         tok_ff.is_match     <= big;
         tok_ff.match_offset <= big ? 10'(best_off_ff) : '0;
         tok_ff.match_length <= big ? 7'(best_len_ff) : '0;
         tok_ff.next_byte    <= big ? la_ff[best_len_ff[BUF_W-1:0]] : la_ff[0];
         tok_ff.tail_done    <= drain_ff &&
                                (big ? (count_ff == best_len_ff + LEN_W'(1))
                                     : (count_ff == LEN_W'(1)));
      end
   end

   assign rsp.valid        = o_valid_ff;
   assign rsp.is_match     = tok_ff.is_match;
   assign rsp.match_offset = tok_ff.match_offset;
   assign rsp.match_length = tok_ff.match_length;
   assign rsp.next_byte    = tok_ff.next_byte;
   assign rsp.tail_done    = tok_ff.tail_done;

   // lookahead never overflows
   a_count: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= BUF_DEPTH) else $error("lookahead overflow");
   // best length within limit when the token is emitted
   a_best: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> best_len_ff <= limit_ff) else $error("run past limit");
   // a token is raised only after an emit
   a_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(o_valid_ff) |-> $past(state_ff) == ST_EMIT) else $error("stray token");
endmodule

@@ hdl/lz77_cell.sv @@
// lz77_cell: one window position of the systolic match search
// depends on lz77_pkg
module lz77_cell
   import lz77_pkg::*;
#(
   parameter int LEN_W = 7
) (
   input  logic             clock,
   input  logic             start,      // clear run, begin comparing
   input  logic             step,       // one lookahead byte broadcast
   input  logic [7:0]       win_byte,   // window byte seen by this cell now
   input  logic [7:0]       la_byte,
   input  logic             in_range,   // position still inside the window
   output logic [LEN_W-1:0] run_len
);
   logic [LEN_W-1:0] run_ff, run_in;
   logic             alive_ff, alive_in;

   always_comb begin
      run_in   = run_ff;
      alive_in = alive_ff;
      if (start) begin
         run_in   = '0;
         alive_in = 1'b1;
      end else if (step && alive_ff) begin
         if (in_range && win_byte == la_byte) begin
            run_in = run_ff + LEN_W'(1);
         end else begin
            alive_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      run_ff   <= run_in;
      alive_ff <= alive_in;
   end

   assign run_len = run_ff;
endmodule
